// ===== design/dsa_pkg.sv =====
`default_nettype none

package dsa_pkg;

  localparam int unsigned HandleW = 10;
  localparam int unsigned PageW   = 10;
  localparam int unsigned CoordW  = 6;
  localparam int unsigned DimW    = 7;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_CELLS_PER_ROW = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ROWS_PER_PAGE = 2'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_HELD = 2'd2
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]         status;
    logic [PageW-1:0]   page;
    logic [CoordW-1:0]  cell_x;
    logic [CoordW-1:0]  cell_y;
    logic               moved;
    logic [HandleW-1:0] moved_handle;
    logic               page_opened;
    logic               page_released;
  } rsp_t;

  // zero reads as one, anything above 64 reads as 64
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = 7'd1;
    end else if (v > 7'd64) begin
      r = 7'd64;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/dsa_req_if.sv =====
`default_nettype none

interface dsa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [dsa_pkg::HandleW-1:0]  handle;

  modport source (output valid, output kind, output handle, input ready);
  modport sink   (input valid, input kind, input handle, output ready);
endinterface

`default_nettype wire

// ===== design/dsa_rsp_if.sv =====
`default_nettype none

interface dsa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [dsa_pkg::PageW-1:0]    page;
  logic [dsa_pkg::CoordW-1:0]   cell_x;
  logic [dsa_pkg::CoordW-1:0]   cell_y;
  logic                         moved;
  logic [dsa_pkg::HandleW-1:0]  moved_handle;
  logic                         page_opened;
  logic                         page_released;

  modport source (output valid, output status, output page, output cell_x, output cell_y,
                  output moved, output moved_handle, output page_opened,
                  output page_released, input ready);
  modport sink   (input valid, input status, input page, input cell_x, input cell_y,
                  input moved, input moved_handle, input page_opened,
                  input page_released, output ready);
endinterface

`default_nettype wire

// ===== design/dense_slot_allocator_swap_remove.sv =====
// Dense slot pool with swap-with-last removal.
// req channel: one word per request, kind (allocate or free) and handle.
// rsp channel: exactly one word per request, status and the cell it touched.
// cfg port: cells_per_row (index 0) and rows_per_page (index 1), taken only
// while the pool is empty; values are clamped to 1..64.
// A request is taken into an input stage that reads the handle table, the
// handle-held bits and the owner of the last occupied slot; once the result
// register is free, the stage checks, writes the tables back and loads the
// result register. A new request is taken only once the one in the input
// stage has gone on to the result register, set by the read-then-write of
// the single-port tables.
// The result register parts the two sides: a request may be accepted while
// a result still waits; if the receiver stalls, the request in the input
// stage holds until the result register frees up.
// After reset the held bits are swept clear, one handle per cycle, over
// min(MAX_HANDLES, 1024) handles; req.ready stays low during the sweep.
`default_nettype none

module dense_slot_allocator_swap_remove #(
  parameter int unsigned MAX_SLOTS   = 1024,
  parameter int unsigned MAX_HANDLES = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  dsa_req_if.sink                            req,
  dsa_rsp_if.source                          rsp,
  input  wire logic                          cfg_we_i,
  input  wire logic [dsa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [dsa_pkg::DimW-1:0]      cfg_wdata_i
);

  localparam int unsigned HDepth = (MAX_HANDLES > 1024) ? 1024 : MAX_HANDLES;
  localparam int unsigned HAW    = (HDepth > 1) ? $clog2(HDepth) : 1;
  localparam int unsigned SAW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned OCW    = $clog2(MAX_SLOTS + 1);

  typedef struct packed {
    logic [dsa_pkg::PageW-1:0]  page;
    logic [dsa_pkg::CoordW-1:0] x;
    logic [dsa_pkg::CoordW-1:0] y;
    logic [SAW-1:0]             slot;
  } loc_t;

  // tables
  logic [dsa_pkg::HandleW-1:0] owner_mem [MAX_SLOTS];
  loc_t                        loc_mem   [HDepth];
  logic                        held_mem  [HDepth];

  // control and pool state
  logic                        busy_q;
  logic                        clearing_q;
  logic [HAW-1:0]              clr_q;
  logic [OCW-1:0]              occ_q, occ_d;
  logic [dsa_pkg::PageW-1:0]   tpage_q, tpage_d;
  logic [dsa_pkg::CoordW-1:0]  tx_q, tx_d;
  logic [dsa_pkg::CoordW-1:0]  ty_q, ty_d;
  logic [dsa_pkg::DimW-1:0]    cpr_q;
  logic [dsa_pkg::DimW-1:0]    rpp_q;

  // input stage
  logic                        kind_q;
  logic [dsa_pkg::HandleW-1:0] hnd_q;
  loc_t                        loc_rd_q;
  logic                        held_rd_q;
  logic [dsa_pkg::HandleW-1:0] owner_rd_q;

  // result register
  logic                        rsp_valid_q;
  dsa_pkg::rsp_t               rsp_q, rsp_d;

  logic                        accept;
  logic                        go;
  logic [HAW-1:0]              in_hidx;
  logic [OCW-1:0]              last_cnt;
  logic [SAW-1:0]              last_slot;

  // write-back
  logic                        own_we;
  logic [SAW-1:0]              own_waddr;
  logic [dsa_pkg::HandleW-1:0] own_wdata;
  logic                        loc_we;
  logic [HAW-1:0]              loc_waddr;
  loc_t                        loc_wdata;
  logic                        held_we;
  logic                        held_wdata;

  assign req.ready = !busy_q && !clearing_q;
  assign accept    = req.valid && req.ready;
  assign go        = busy_q && (!rsp_valid_q || rsp.ready);
  assign in_hidx   = req.handle[HAW-1:0];
  assign last_cnt  = occ_q - OCW'(1);
  assign last_slot = last_cnt[SAW-1:0];

  always_comb begin
    logic                        h_bad;
    logic [HAW-1:0]              hidx;
    logic [dsa_pkg::DimW-1:0]    x_inc;
    logic [dsa_pkg::DimW-1:0]    y_inc;
    logic [dsa_pkg::PageW-1:0]   lp;
    logic [dsa_pkg::CoordW-1:0]  lx;
    logic [dsa_pkg::CoordW-1:0]  ly;
    h_bad = {7'd0, hnd_q} >= 17'(MAX_HANDLES);
    hidx  = hnd_q[HAW-1:0];
    x_inc = {1'b0, tx_q} + 7'd1;
    y_inc = {1'b0, ty_q} + 7'd1;

    rsp_d      = '0;
    occ_d      = occ_q;
    tpage_d    = tpage_q;
    tx_d       = tx_q;
    ty_d       = ty_q;
    own_we     = 1'b0;
    own_waddr  = occ_q[SAW-1:0];
    own_wdata  = hnd_q;
    loc_we     = 1'b0;
    loc_waddr  = hidx;
    loc_wdata  = '{page: tpage_q, x: tx_q, y: ty_q, slot: occ_q[SAW-1:0]};
    held_we    = 1'b0;
    held_wdata = 1'b0;

    // cell just before the next free position
    lp = tpage_q;
    lx = tx_q;
    ly = ty_q;
    if (tx_q != '0) begin
      lx = tx_q - 6'd1;
    end else begin
      lx = 6'(cpr_q - 7'd1);
      if (ty_q != '0) begin
        ly = ty_q - 6'd1;
      end else begin
        ly = 6'(rpp_q - 7'd1);
        lp = tpage_q - 10'd1;
      end
    end

    if (kind_q == dsa_pkg::KIND_ALLOC) begin
      if (occ_q == OCW'(MAX_SLOTS)) begin
        rsp_d.status = dsa_pkg::ST_FULL;
      end else if (h_bad || held_rd_q) begin
        rsp_d.status = dsa_pkg::ST_NOT_HELD;
      end else begin
        rsp_d.status      = dsa_pkg::ST_OK;
        rsp_d.page        = tpage_q;
        rsp_d.cell_x      = tx_q;
        rsp_d.cell_y      = ty_q;
        rsp_d.page_opened = (tx_q == '0) && (ty_q == '0);
        own_we     = 1'b1;
        loc_we     = 1'b1;
        held_we    = 1'b1;
        held_wdata = 1'b1;
        occ_d      = occ_q + OCW'(1);
        if (x_inc >= cpr_q) begin
          tx_d = '0;
          if (y_inc >= rpp_q) begin
            ty_d    = '0;
            tpage_d = tpage_q + 10'd1;
          end else begin
            ty_d = y_inc[dsa_pkg::CoordW-1:0];
          end
        end else begin
          tx_d = x_inc[dsa_pkg::CoordW-1:0];
        end
      end
    end else begin
      if (h_bad || !held_rd_q || occ_q == '0) begin
        rsp_d.status = dsa_pkg::ST_NOT_HELD;
      end else begin
        rsp_d.status        = dsa_pkg::ST_OK;
        rsp_d.page          = loc_rd_q.page;
        rsp_d.cell_x        = loc_rd_q.x;
        rsp_d.cell_y        = loc_rd_q.y;
        rsp_d.page_released = (lx == '0) && (ly == '0);
        held_we = 1'b1;
        // the last handle moves into the freed cell unless they coincide
        if (loc_rd_q.page != lp || loc_rd_q.x != lx || loc_rd_q.y != ly) begin
          rsp_d.moved        = 1'b1;
          rsp_d.moved_handle = owner_rd_q;
          own_we    = 1'b1;
          own_waddr = loc_rd_q.slot;
          own_wdata = owner_rd_q;
          loc_we    = 1'b1;
          loc_waddr = owner_rd_q[HAW-1:0];
          loc_wdata = loc_rd_q;
        end
        occ_d   = last_cnt;
        tpage_d = lp;
        tx_d    = lx;
        ty_d    = ly;
      end
    end
  end

  // table ports
  always_ff @(posedge clk_i) begin
    if (accept) begin
      loc_rd_q   <= loc_mem[in_hidx];
      owner_rd_q <= owner_mem[last_slot];
      held_rd_q  <= held_mem[in_hidx];
      kind_q     <= req.kind;
      hnd_q      <= req.handle;
    end
    if (go && own_we) begin
      owner_mem[own_waddr] <= own_wdata;
    end
    if (go && loc_we) begin
      loc_mem[loc_waddr] <= loc_wdata;
    end
    if (clearing_q) begin
      held_mem[clr_q] <= 1'b0;
    end else if (go && held_we) begin
      held_mem[hnd_q[HAW-1:0]] <= held_wdata;
    end
    if (go) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
      occ_q       <= '0;
      tpage_q     <= '0;
      tx_q        <= '0;
      ty_q        <= '0;
      cpr_q       <= 7'd16;
      rpp_q       <= 7'd16;
    end else begin
      if (clearing_q) begin
        clr_q <= clr_q + HAW'(1);
        if (clr_q == HAW'(HDepth - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (go) begin
        busy_q <= 1'b0;
      end
      if (go) begin
        rsp_valid_q <= 1'b1;
        occ_q       <= occ_d;
        tpage_q     <= tpage_d;
        tx_q        <= tx_d;
        ty_q        <= ty_d;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg_we_i && occ_q == '0) begin
        unique case (cfg_idx_i)
          dsa_pkg::REG_CELLS_PER_ROW: cpr_q <= dsa_pkg::clamp_dim(cfg_wdata_i);
          dsa_pkg::REG_ROWS_PER_PAGE: rpp_q <= dsa_pkg::clamp_dim(cfg_wdata_i);
          default: ;
        endcase
      end
    end
  end

  assign rsp.valid         = rsp_valid_q;
  assign rsp.status        = rsp_q.status;
  assign rsp.page          = rsp_q.page;
  assign rsp.cell_x        = rsp_q.cell_x;
  assign rsp.cell_y        = rsp_q.cell_y;
  assign rsp.moved         = rsp_q.moved;
  assign rsp.moved_handle  = rsp_q.moved_handle;
  assign rsp.page_opened   = rsp_q.page_opened;
  assign rsp.page_released = rsp_q.page_released;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted word did not enter the input stage");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCW'(MAX_SLOTS))
    else $error("occupied count beyond pool size");

  a_tail_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, tx_q} < cpr_q) && ({1'b0, ty_q} < rpp_q))
    else $error("tail position outside the page");

  a_empty_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> (tpage_q == '0 && tx_q == '0 && ty_q == '0))
    else $error("empty pool with nonzero tail");

  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !req.ready && !busy_q)
    else $error("request taken during held-bit sweep");

endmodule

`default_nettype wire
